// ===== design/sabs_pkg.sv =====
package sabs_pkg;

  // input beat
  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
    logic               last;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic       kind;
    logic [1:0] order;
    logic       found;
    logic [7:0] index;
  } out_beat_t;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] ORDER_ASC    = 2'd0;
  localparam logic [1:0] ORDER_DESC   = 2'd1;
  localparam logic [1:0] ORDER_SORTED = 2'd2;
  localparam logic [1:0] ORDER_EMPTY  = 2'd3;

endpackage

// ===== design/sabs_ram.sv =====
module sabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sorted_array_binary_search_top.sv =====
// channel | ports                          | beat
// --------+--------------------------------+-----------------------------------
// input   | in_valid, in_ready, in_data    | sabs_pkg::in_beat_t  (mode,value,last)
// result  | out_valid, out_ready, out_data | sabs_pkg::out_beat_t (kind,order,found,index)
//
// load beat not last: block stays idle; last beat of an ordered array: result via the emit state
// unsorted array: bubble sort in the element ram, at most DEPTH-1 passes,
// stopping after a pass with no swap
// search: probes <= log2(DEPTH) + 1, one ram read per probe
// rst_n synchronous, active low, ram not cleared; a waiting result lets beats in until
// one owes a result, held in the emit state with in_ready low until the register frees
module sorted_array_binary_search_top #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sabs_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sabs_pkg::out_beat_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD0,
    S_SORT_LD0,
    S_SORT_STEP,
    S_SORT_END,
    S_SRCH,
    S_EMIT
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                load_done_r, load_done_nxt;
  logic [1:0]          order_r, order_nxt;
  logic                never_rises_r, never_rises_nxt;
  logic                never_falls_r, never_falls_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working registers
  logic signed [31:0]  last_val_r, last_val_nxt;
  logic signed [31:0]  target_r, target_nxt;
  logic [CW-1:0]       low_r, low_nxt;
  logic [CW-1:0]       hip_r, hip_nxt;     // high + 1
  logic [AW-1:0]       mid_r, mid_nxt;
  logic signed [31:0]  carry_r, carry_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       limit_r, limit_nxt;
  logic                swapped_r, swapped_nxt;
  sabs_pkg::out_beat_t res_r, res_nxt;
  sabs_pkg::out_beat_t out_r, out_nxt;

  // ram port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         ram_rdata;
  logic signed [31:0]  rd_val;

  // helpers
  logic                in_fire;
  logic [CW-1:0]       base_count;
  logic                base_rises, base_falls;
  logic [CW:0]         first_sum;
  logic [CW-1:0]       cand_low, cand_hip;
  logic [CW:0]         cand_sum;
  logic                go_high;

  sabs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val    = $signed(ram_rdata);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a load after a finished one starts a fresh array
  assign base_count = load_done_r ? '0 : count_r;
  assign base_rises = load_done_r ? 1'b1 : never_rises_r;
  assign base_falls = load_done_r ? 1'b1 : never_falls_r;

  // first probe: mid of [0, count-1]
  assign first_sum = {1'b0, count_r} - (CW + 1)'(1);

  // next window after a miss in the probe stage
  assign go_high  = (rd_val > target_r) != (order_r == sabs_pkg::ORDER_DESC);
  assign cand_low = go_high ? low_r : (CW'(mid_r) + CW'(1));
  assign cand_hip = go_high ? CW'(mid_r) : hip_r;
  assign cand_sum = {1'b0, cand_low} + {1'b0, cand_hip} - (CW + 1)'(1);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    load_done_nxt   = load_done_r;
    order_nxt       = order_r;
    never_rises_nxt = never_rises_r;
    never_falls_nxt = never_falls_r;
    out_valid_nxt   = out_valid_r;
    last_val_nxt    = last_val_r;
    target_nxt      = target_r;
    low_nxt         = low_r;
    hip_nxt         = hip_r;
    mid_nxt         = mid_r;
    carry_nxt       = carry_r;
    j_nxt           = j_r;
    limit_nxt       = limit_r;
    swapped_nxt     = swapped_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_raddr       = '0;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.mode == sabs_pkg::MODE_LOAD) begin
          count_nxt       = base_count;
          never_rises_nxt = base_rises;
          never_falls_nxt = base_falls;
          order_nxt       = load_done_r ? sabs_pkg::ORDER_EMPTY : order_r;
          load_done_nxt   = 1'b0;
          if (base_count < CW'(DEPTH)) begin
            if (base_count != '0) begin
              if (in_data.value > last_val_r) never_rises_nxt = 1'b0;
              if (in_data.value < last_val_r) never_falls_nxt = 1'b0;
            end
            ram_we       = 1'b1;
            ram_waddr    = AW'(base_count);
            ram_wdata    = in_data.value;
            last_val_nxt = in_data.value;
            count_nxt    = base_count + CW'(1);
          end
          if (in_data.last) begin
            load_done_nxt = 1'b1;
            res_nxt.kind  = sabs_pkg::KIND_LOAD;
            res_nxt.found = 1'b0;
            res_nxt.index = '0;
            if (never_rises_nxt) begin
              order_nxt     = sabs_pkg::ORDER_DESC;
              res_nxt.order = sabs_pkg::ORDER_DESC;
              state_nxt     = S_EMIT;
            end else if (never_falls_nxt) begin
              order_nxt     = sabs_pkg::ORDER_ASC;
              res_nxt.order = sabs_pkg::ORDER_ASC;
              state_nxt     = S_EMIT;
            end else begin
              // unsorted: first pass bounds the whole array
              limit_nxt   = AW'(count_nxt - CW'(1));
              swapped_nxt = 1'b0;
              state_nxt   = S_SORT_RD0;
            end
          end
        end else if (in_fire) begin
          res_nxt.kind  = sabs_pkg::KIND_SEARCH;
          res_nxt.order = order_r;
          res_nxt.found = 1'b0;
          res_nxt.index = '0;
          if (!load_done_r || count_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            target_nxt = in_data.value;
            low_nxt    = '0;
            hip_nxt    = count_r;
            mid_nxt    = AW'(first_sum >> 1);
            ram_raddr  = AW'(first_sum >> 1);
            state_nxt  = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (rd_val == target_r) begin
          res_nxt.found = 1'b1;
          res_nxt.index = 8'(mid_r);
          state_nxt     = S_EMIT;
        end else if (cand_low < cand_hip) begin
          low_nxt   = cand_low;
          hip_nxt   = cand_hip;
          mid_nxt   = AW'(cand_sum >> 1);
          ram_raddr = AW'(cand_sum >> 1);
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_SORT_RD0: begin
        ram_raddr = '0;
        state_nxt = S_SORT_LD0;
      end

      S_SORT_LD0: begin
        carry_nxt = rd_val;
        j_nxt     = '0;
        ram_raddr = AW'(1);
        state_nxt = S_SORT_STEP;
      end

      S_SORT_STEP: begin
        // carry holds the largest seen so far in this pass
        ram_we    = 1'b1;
        ram_waddr = j_r;
        if (carry_r > rd_val) begin
          ram_wdata   = rd_val;
          swapped_nxt = 1'b1;
        end else begin
          ram_wdata = carry_r;
          carry_nxt = rd_val;
        end
        if (j_r + AW'(1) == limit_r) begin
          state_nxt = S_SORT_END;
        end else begin
          ram_raddr = j_r + AW'(1) + AW'(1);
          j_nxt     = j_r + AW'(1);
        end
      end

      S_SORT_END: begin
        ram_we    = 1'b1;
        ram_waddr = limit_r;
        ram_wdata = carry_r;
        if (!swapped_r || limit_r == AW'(1)) begin
          order_nxt     = sabs_pkg::ORDER_SORTED;
          res_nxt.order = sabs_pkg::ORDER_SORTED;
          state_nxt     = S_EMIT;
        end else begin
          limit_nxt   = limit_r - AW'(1);
          swapped_nxt = 1'b0;
          state_nxt   = S_SORT_RD0;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      load_done_r   <= 1'b0;
      order_r       <= sabs_pkg::ORDER_EMPTY;
      never_rises_r <= 1'b1;
      never_falls_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      load_done_r   <= load_done_nxt;
      order_r       <= order_nxt;
      never_rises_r <= never_rises_nxt;
      never_falls_r <= never_falls_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    last_val_r <= last_val_nxt;
    target_r   <= target_nxt;
    low_r      <= low_nxt;
    hip_r      <= hip_nxt;
    mid_r      <= mid_nxt;
    carry_r    <= carry_nxt;
    j_r        <= j_nxt;
    limit_r    <= limit_nxt;
    swapped_r  <= swapped_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

// ===== sim/sorted_array_binary_search_top_tb.sv =====
module sorted_array_binary_search_top_tb;

  localparam int DEPTH        = 256;
  localparam int N_BEATS      = 1400;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int STALL_CYCLES = 300;
  // drain slack after the last answer, well above the longest search
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  sabs_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sabs_pkg::out_beat_t out_data;

  sorted_array_binary_search_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the block: element array, count, order flags
  // ---------------------------------------------------------------------------
  logic signed [31:0] elem_mem [DEPTH];
  int unsigned        elem_cnt;
  bit                 arr_closed;   // a load has finished, searches are live
  logic [1:0]         arr_order;
  bit                 no_rise;
  bit                 no_fall;

  sabs_pkg::out_beat_t pending_answers[$];  // answers still owed by the block, oldest first
  int                  errors;
  int                  beats_sent;
  int                  cycle_cnt;
  bit                  quiet;               // no idling on either side while set
  bit                  stall_req;           // asks the receiver for one long hold-off
  sabs_pkg::out_beat_t want;

  // values of the array being loaded, used to pick search targets
  logic signed [31:0] cur_vals[$];

  // directed stimulus table
  typedef struct {
    sabs_pkg::in_beat_t  beat;
    bit                  typed;
    sabs_pkg::out_beat_t ans;
  } vec_t;
  vec_t dir_rows[$];

  function automatic void clear_array();
    elem_cnt   = 0;
    arr_closed = 1'b0;
    arr_order  = sabs_pkg::ORDER_EMPTY;
    no_rise    = 1'b1;
    no_fall    = 1'b1;
  endfunction

  // ascending bubble sort over the loaded part of the array
  function automatic void sort_elems();
    logic signed [31:0] t;
    bit swapped;
    for (int p = 0; p + 1 < int'(elem_cnt); p++) begin
      swapped = 1'b0;
      for (int j = 0; j + 1 < int'(elem_cnt) - p; j++) begin
        if (elem_mem[j] > elem_mem[j+1]) begin
          t             = elem_mem[j];
          elem_mem[j]   = elem_mem[j+1];
          elem_mem[j+1] = t;
          swapped       = 1'b1;
        end
      end
      if (!swapped) break;
    end
  endfunction

  // applies one accepted beat to the shadow state; returns 1 when the block owes an answer
  function automatic bit apply_beat(input sabs_pkg::in_beat_t b,
                                    output sabs_pkg::out_beat_t r);
    int lo;
    int hi;
    int mid;
    bit desc;
    r = '0;
    if (b.mode == sabs_pkg::MODE_LOAD) begin
      // first element after a finished load opens a new array
      if (arr_closed) clear_array();
      // full array: extra elements are dropped but last still closes the load
      if (elem_cnt < DEPTH) begin
        if (elem_cnt > 0) begin
          if (b.value > elem_mem[elem_cnt-1]) no_rise = 1'b0;
          if (b.value < elem_mem[elem_cnt-1]) no_fall = 1'b0;
        end
        elem_mem[elem_cnt] = b.value;
        elem_cnt++;
      end
      if (!b.last) return 1'b0;
      // flat or single element arrays count as descending
      if (no_rise) arr_order = sabs_pkg::ORDER_DESC;
      else if (no_fall) arr_order = sabs_pkg::ORDER_ASC;
      else begin
        sort_elems();
        arr_order = sabs_pkg::ORDER_SORTED;
      end
      arr_closed = 1'b1;
      r.kind  = sabs_pkg::KIND_LOAD;
      r.order = arr_order;
      return 1'b1;
    end
    // search: nothing to look at until a load has closed
    r.kind  = sabs_pkg::KIND_SEARCH;
    r.order = arr_closed ? arr_order : sabs_pkg::ORDER_EMPTY;
    if (arr_closed && elem_cnt > 0) begin
      lo   = 0;
      hi   = int'(elem_cnt) - 1;
      desc = (arr_order == sabs_pkg::ORDER_DESC);
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        // with duplicates the first probe that hits wins
        if (elem_mem[mid] == b.value) begin
          r.found = 1'b1;
          r.index = mid[7:0];
          break;
        end
        if ((elem_mem[mid] > b.value) != desc) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic sabs_pkg::out_beat_t answer(logic k, logic [1:0] o, logic f,
                                                 logic [7:0] i);
    sabs_pkg::out_beat_t r;
    r.kind  = k;
    r.order = o;
    r.found = f;
    r.index = i;
    return r;
  endfunction

  task automatic add_row(logic m, logic signed [31:0] v, logic l, bit t,
                         sabs_pkg::out_beat_t a);
    vec_t e;
    e.beat.mode  = m;
    e.beat.value = v;
    e.beat.last  = l;
    e.typed      = t;
    e.ans        = a;
    dir_rows.push_back(e);
  endtask

  function automatic logic signed [31:0] rand_word(bit narrow);
    // narrow range makes duplicates and equal neighbors likely
    if (narrow) return $signed($urandom_range(16)) - 32'sd8;
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one beat per call, random gaps ahead of it
  // entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input sabs_pkg::in_beat_t b, input bit typed,
                           input sabs_pkg::out_beat_t typed_ans);
    sabs_pkg::out_beat_t r;
    bit                  has;
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge: update the shadow state right away
    has = apply_beat(b, r);
    if (has) pending_answers.push_back(typed ? typed_ans : r);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_search(logic signed [31:0] target);
    sabs_pkg::in_beat_t b;
    b.mode  = sabs_pkg::MODE_SEARCH;
    b.value = target;
    b.last  = 1'($urandom_range(1));   // ignored by the block on searches
    send_beat(b, 1'b0, '0);
  endtask

  // one array load of n elements followed by a few searches
  // shape: 0 ascending, 1 descending, 2 flat, 3 random, 4 nearly ascending
  task automatic load_and_search(int n, int shape, bit narrow, bit stray);
    sabs_pkg::in_beat_t b;
    int                 k;
    int                 pick;
    int                 stray_at;
    logic signed [31:0] t;
    cur_vals.delete();
    for (int i = 0; i < n; i++) cur_vals.push_back(rand_word(narrow));
    case (shape)
      0: begin
        cur_vals.sort();
      end
      1: begin
        cur_vals.rsort();
      end
      2: begin
        foreach (cur_vals[i]) cur_vals[i] = cur_vals[0];
      end
      4: begin
        cur_vals.sort();
        if (n > 2) begin
          k             = $urandom_range(n - 2);
          t             = cur_vals[k];
          cur_vals[k]   = cur_vals[k+1];
          cur_vals[k+1] = t;
        end
      end
      default: begin
      end
    endcase
    // broken sequence: a search lands in the middle of the load
    stray_at = stray ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == stray_at) send_search(rand_word(narrow));
      b.mode  = sabs_pkg::MODE_LOAD;
      b.value = cur_vals[i];
      b.last  = (i == n - 1);
      send_beat(b, 1'b0, '0);
    end
    k = $urandom_range(1, 8);
    repeat (k) begin
      pick = $urandom_range(99);
      t    = cur_vals[$urandom_range(n - 1)];
      if (pick >= 85) t = rand_word(narrow);
      else if (pick >= 70) t = $urandom_range(1) ? t + 32'sd1 : t - 32'sd1;
      send_search(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        // hold off long enough for the block to fill and drop in_ready
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  // every result beat is matched against the oldest owed answer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
      end else begin
        want = pending_answers.pop_front();
        check_field("kind",  32'(want.kind),  32'(out_data.kind));
        check_field("order", 32'(want.order), 32'(out_data.order));
        check_field("found", 32'(want.found), 32'(out_data.found));
        check_field("index", 32'(want.index), 32'(out_data.index));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit big_sorted_done;
    bit big_mixed_done;
    bit stalled;
    int r;
    int n;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    quiet           = 1'b0;
    stall_req       = 1'b0;
    errors          = 0;
    beats_sent      = 0;
    cycle_cnt       = 0;
    big_sorted_done = 1'b0;
    big_mixed_done  = 1'b0;
    stalled         = 1'b0;
    clear_array();

    // search before any load, with last set to show it is ignored
    add_row(sabs_pkg::MODE_SEARCH, 32'sd0, 1'b1, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_EMPTY, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_LOAD,   MAXV,   1'b0, 1'b0, '0);
    // search while the load is still open
    add_row(sabs_pkg::MODE_SEARCH, 32'sd5, 1'b0, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_EMPTY, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_LOAD,   MINV,   1'b0, 1'b0, '0);
    // max, min, 0 is unsorted: gets sorted to min, 0, max
    add_row(sabs_pkg::MODE_LOAD,   32'sd0, 1'b1, 1'b1,
            answer(sabs_pkg::KIND_LOAD, sabs_pkg::ORDER_SORTED, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, MINV,   1'b0, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_SORTED, 1'b1, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, MAXV,   1'b1, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_SORTED, 1'b1, 8'd2));
    add_row(sabs_pkg::MODE_SEARCH, 32'sd0, 1'b0, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_SORTED, 1'b1, 8'd1));
    add_row(sabs_pkg::MODE_SEARCH, 32'sd1, 1'b0, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_SORTED, 1'b0, 8'd0));
    // single element array counts as descending
    add_row(sabs_pkg::MODE_LOAD,   32'sd42, 1'b1, 1'b1,
            answer(sabs_pkg::KIND_LOAD, sabs_pkg::ORDER_DESC, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, 32'sd42, 1'b0, 1'b1,
            answer(sabs_pkg::KIND_SEARCH, sabs_pkg::ORDER_DESC, 1'b1, 8'd0));
    // flat array also descending, duplicate target
    add_row(sabs_pkg::MODE_LOAD,   32'sd7, 1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   32'sd7, 1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   32'sd7, 1'b1, 1'b1,
            answer(sabs_pkg::KIND_LOAD, sabs_pkg::ORDER_DESC, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, 32'sd7, 1'b0, 1'b0, '0);
    // ascending with a repeated value
    add_row(sabs_pkg::MODE_LOAD,   -32'sd5, 1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   32'sd3,  1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   32'sd3,  1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   32'sd9,  1'b1, 1'b1,
            answer(sabs_pkg::KIND_LOAD, sabs_pkg::ORDER_ASC, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, 32'sd3,  1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_SEARCH, 32'sd9,  1'b1, 1'b0, '0);
    add_row(sabs_pkg::MODE_SEARCH, -32'sd6, 1'b0, 1'b0, '0);
    // strictly descending pair, search both ends
    add_row(sabs_pkg::MODE_LOAD,   32'sd100,  1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_LOAD,   -32'sd100, 1'b1, 1'b1,
            answer(sabs_pkg::KIND_LOAD, sabs_pkg::ORDER_DESC, 1'b0, 8'd0));
    add_row(sabs_pkg::MODE_SEARCH, -32'sd100, 1'b0, 1'b0, '0);
    add_row(sabs_pkg::MODE_SEARCH, 32'sd100,  1'b0, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].ans);

    // random loads and searches
    while (beats_sent < N_BEATS) begin
      // one idle-free stretch in the middle of the run
      quiet = (beats_sent >= 700 && beats_sent < 900);
      if (!stalled && beats_sent >= 550) begin
        stall_req = 1'b1;
        stalled   = 1'b1;
      end
      if (!big_sorted_done && beats_sent >= 400) begin
        // overflowing ascending load: tail elements dropped
        big_sorted_done = 1'b1;
        load_and_search(DEPTH + 2, 0, 1'b0, 1'b0);
      end else if (!big_mixed_done && beats_sent >= 950) begin
        // full-size unsorted load, one long sort
        big_mixed_done = 1'b1;
        load_and_search(DEPTH + 1, 3, 1'b0, 1'b0);
      end else begin
        r = $urandom_range(99);
        if (r < 70) n = $urandom_range(1, 12);
        else if (r < 95) n = $urandom_range(13, 40);
        else n = $urandom_range(41, 100);
        load_and_search(n, $urandom_range(4), $urandom_range(99) < 40,
                        $urandom_range(99) < 10);
      end
    end

    // still at the falling edge after the last beat was taken
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sabs_pkg.sv
design/sabs_ram.sv
design/sorted_array_binary_search_top.sv
sim/sorted_array_binary_search_top_tb.sv
